### rtl/core/radar_detector_law_core_assert.svh
// assertion macros for the radar detector law core
// used by files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef RADAR_DETECTOR_LAW_CORE_ASSERT_SVH
`define RADAR_DETECTOR_LAW_CORE_ASSERT_SVH

// check that is off while reset is asserted
`define RDL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also runs during reset
`define RDL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/rdl_pkg.sv
// shared types and constants of the radar detector law core
// no dependencies
package rdl_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int OUT_WIDTH_DEF    = 32;
  localparam int CFG_W            = 24;
  localparam int LOG_FRAC         = 28;
  localparam int NORM_W           = 64;
  localparam int MANT_W           = 32;
  localparam int EXP_W            = 6;
  localparam int TW               = 37;

  // ln 2 in Q.28
  localparam logic [LOG_FRAC-1:0] LN2_Q28 = 28'd186065279;

  typedef enum logic [1:0] {
    DET_ENV    = 2'd0,
    DET_SQUARE = 2'd1,
    DET_LOGSQ  = 2'd2,
    DET_LOG    = 2'd3
  } det_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_LOGZERO = 2'd2;

  localparam logic [1:0] REG_TYPE   = 2'd0;
  localparam logic [1:0] REG_COEF_A = 2'd1;
  localparam logic [1:0] REG_COEF_B = 2'd2;

  localparam logic [CFG_W-1:0] COEF_RST = 24'd65536;

  typedef struct packed {
    logic valid;
    det_e det_type;
    logic eom;
    logic log_zero;
  } ctl_t;

endpackage

### rtl/core/radar_detector_law_core.sv
// radar detector law core: top level, input and output stages, post processing
// depends on rdl_pkg, rdl_lognorm, rdl_cell and radar_detector_law_core_assert.svh
//
// One complex sample (I, Q, signed Q1.(SAMPLE_WIDTH-1)) enters per request and one
// signed Q8.(OUT_WIDTH-8) result leaves per request, in order, with the end-of-matrix
// mark copied to tlast and a status in tuser (ok, saturated, log of zero). The law is
// picked by the detector_type register: envelope, square, log square a*ln(|b*x|^2) or
// log a*ln(|b*x|). The core takes a new sample every cycle while the sink keeps up. A
// sample passes the sample register, three input stages (power, two normalization
// steps), the row of cells, each giving at most one square-root digit and one log2
// fraction bit, four post stages (log2 sum, two stages for the ln 2 scale, one for
// the gain a) and the output register.
// The whole pipe advances while the output register is empty or taken, so tready
// drops only when a result is held back by the sink. Registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i and must only change while the core is empty.
`include "radar_detector_law_core_assert.svh"

module radar_detector_law_core #(
  parameter int SAMPLE_WIDTH = rdl_pkg::SAMPLE_WIDTH_DEF,
  parameter int OUT_WIDTH    = rdl_pkg::OUT_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // in_real, in_imag, zero fill
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // detected, zero fill
  output logic [((OUT_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  output logic                                  m_axis_tlast,
  // result_status
  output logic [1:0]                            m_axis_tuser,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_idx_i,
  input  logic [rdl_pkg::CFG_W-1:0]             cfg_data_i
);
  import rdl_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int OW     = OUT_WIDTH;
  localparam int SF     = SW - 1;
  localparam int OF     = OW - 8;
  localparam int PW     = 2 * SW;
  localparam int NSQ    = OW - 7;
  localparam int RW     = NSQ + 3;
  localparam int NCELL  = (NSQ > LOG_FRAC) ? NSQ : LOG_FRAC;
  localparam int NST    = NCELL + 8;
  localparam int NA     = NCELL + 7;
  localparam int SQ_SH  = 2 * SF - OF;
  localparam int SQ_L   = (SQ_SH < 0) ? -SQ_SH : 0;
  localparam int SQW    = PW + 1 + SQ_L + OW;
  localparam int DOUT_W = ((OW + 7) / 8) * 8;
  localparam int SH_LSQ = 44 - OF;
  localparam int SH_LOG = 45 - OF;
  localparam int YW     = 62;

  localparam logic [OW-1:0]        OMAX_U = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0]        OMIN_U = {1'b1, {(OW-1){1'b0}}};
  localparam logic signed [YW-1:0] YMAX   = (YW'(1) <<< (OW - 1)) - YW'(1);
  localparam logic signed [YW-1:0] YMIN   = -YMAX - YW'(1);
  localparam logic [TW-1:0]        TOFF   = TW'(32 + 2 * SF) << LOG_FRAC;

  // configuration registers
  det_e                    type_q;
  logic signed [CFG_W-1:0] coef_a_q;
  logic [CFG_W-1:0]        coef_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q   <= DET_SQUARE;
      coef_a_q <= COEF_RST;
      coef_b_q <= COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TYPE:   type_q   <= det_e'(cfg_data_i[1:0]);
        REG_COEF_A: coef_a_q <= cfg_data_i;
        REG_COEF_B: coef_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves whenever the output register can take a result
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // control line through every stage
  ctl_t ctl_q [NST];
  ctl_t ctl_in;
  ctl_t ctl_s2;
  logic log_zero;

  assign ctl_in = '{valid: s_axis_tvalid, det_type: type_q, eom: s_axis_tlast,
                    log_zero: 1'b0};

  // log of zero flag joins the control word on its way into stage two
  assign ctl_s2 = '{valid: ctl_q[1].valid, det_type: ctl_q[1].det_type,
                    eom: ctl_q[1].eom, log_zero: log_zero};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) ctl_q[i] <= '0;
    end else if (en) begin
      ctl_q[0] <= ctl_in;
      ctl_q[1] <= ctl_q[0];
      ctl_q[2] <= ctl_s2;
      for (int i = 3; i < NST; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  // sample stage and power stage
  logic [SW-1:0]       re1_q, im1_q, mr, mi;
  logic [CFG_W-1:0]    b1_q, b2_q;
  logic [PW-1:0]       p_d, p2_q, p3_q, p4_q;
  logic signed [CFG_W-1:0] a_ln [NA];

  assign mr  = re1_q[SW-1] ? (~re1_q + SW'(1)) : re1_q;
  assign mi  = im1_q[SW-1] ? (~im1_q + SW'(1)) : im1_q;
  assign p_d = PW'(mr) * PW'(mr) + PW'(mi) * PW'(mi);

  // log of zero when either log operand is zero
  assign log_zero = (p2_q == '0) || (b2_q == '0);

  // square law with round half up, or left shift when the output has more fraction
  logic [SQW-1:0] sq_w;
  logic           sq_big;

  if (SQ_SH > 0) begin : g_sq_rnd
    assign sq_w = (SQW'(p2_q) + (SQW'(1) << (SQ_SH - 1))) >> SQ_SH;
  end else begin : g_sq_shl
    assign sq_w = SQW'(p2_q) << SQ_L;
  end
  assign sq_big = sq_w > SQW'(OMAX_U);

  logic [OW-2:0] sq_ln  [NCELL+2];
  logic          big_ln [NCELL+2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      re1_q    <= s_axis_tdata[SW-1:0];
      im1_q    <= s_axis_tdata[2*SW-1:SW];
      b1_q     <= coef_b_q;
      a_ln[0]  <= coef_a_q;
      for (int i = 1; i < NA; i++) a_ln[i] <= a_ln[i-1];
      p2_q     <= p_d;
      b2_q     <= b1_q;
      p3_q     <= p2_q;
      p4_q     <= p3_q;
      sq_ln[0]  <= sq_w[OW-2:0];
      big_ln[0] <= sq_big;
      for (int i = 1; i < NCELL + 2; i++) begin
        sq_ln[i]  <= sq_ln[i-1];
        big_ln[i] <= big_ln[i-1];
      end
    end
  end

  // normalization of b and of the power ahead of the log cells
  logic [EXP_W-1:0]  eb_s4, ep_s4;
  logic [MANT_W-1:0] mb_s4, mp_s4;

  rdl_lognorm u_norm_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (NORM_W'(b2_q)),
    .exp_o  (eb_s4),
    .mant_o (mb_s4)
  );

  rdl_lognorm u_norm_p (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (NORM_W'(p2_q)),
    .exp_o  (ep_s4),
    .mant_o (mp_s4)
  );

  // row of cells: square-root digits and log2 fraction bits
  logic [PW-1:0]       cp  [NCELL+1];
  logic [NSQ-1:0]      cr  [NCELL+1];
  logic [RW-1:0]       cm  [NCELL+1];
  logic [MANT_W-1:0]   cmb [NCELL+1];
  logic [MANT_W-1:0]   cmp [NCELL+1];
  logic [LOG_FRAC-1:0] cfb [NCELL+1];
  logic [LOG_FRAC-1:0] cfp [NCELL+1];
  logic [EXP_W-1:0]    eb_ln [NCELL];
  logic [EXP_W-1:0]    ep_ln [NCELL];

  assign cp[0]  = p4_q;
  assign cr[0]  = '0;
  assign cm[0]  = '0;
  assign cmb[0] = mb_s4;
  assign cmp[0] = mp_s4;
  assign cfb[0] = '0;
  assign cfp[0] = '0;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    rdl_cell #(
      .SAMPLE_WIDTH (SW),
      .OUT_WIDTH    (OW),
      .IDX          (g)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .p_i    (cp[g]),
      .p_o    (cp[g+1]),
      .root_i (cr[g]),
      .root_o (cr[g+1]),
      .rem_i  (cm[g]),
      .rem_o  (cm[g+1]),
      .mb_i   (cmb[g]),
      .mb_o   (cmb[g+1]),
      .mp_i   (cmp[g]),
      .mp_o   (cmp[g+1]),
      .fb_i   (cfb[g]),
      .fb_o   (cfb[g+1]),
      .fp_i   (cfp[g]),
      .fp_o   (cfp[g+1])
    );
  end

  // exponents ride alongside the cells
  always_ff @(posedge clk_i) begin
    if (en) begin
      eb_ln[0] <= eb_s4;
      ep_ln[0] <= ep_s4;
      for (int i = 1; i < NCELL; i++) begin
        eb_ln[i] <= eb_ln[i-1];
        ep_ln[i] <= ep_ln[i-1];
      end
    end
  end

  // first post stage: root rounding, law select for linear laws, log2 sum T
  logic [NSQ:0]    root_r;
  logic [OW-1:0]   lin_d;
  logic            big_d;
  logic [TW-1:0]   t_d, t_q;
  logic [OW-1:0]   lin_ln [4];
  logic            bigl_ln [4];
  ctl_t            ctl_c;

  assign ctl_c  = ctl_q[3+NCELL];
  assign root_r = (NSQ+1)'(cr[NCELL]) + (NSQ+1)'(cm[NCELL] > RW'(cr[NCELL]));

  always_comb begin
    if (ctl_c.det_type == DET_ENV) begin
      lin_d = OW'(root_r);
      big_d = OW'(root_r) > OMAX_U;
    end else begin
      lin_d = {1'b0, sq_ln[NCELL+1]};
      big_d = big_ln[NCELL+1];
    end
  end

  // T = 2*lg(b) + lg(P) - (32 + 2*SF), Q.28
  assign t_d = TW'({eb_ln[NCELL-1], cfb[NCELL], 1'b0})
             + TW'({ep_ln[NCELL-1], cfp[NCELL]}) - TOFF;

  // ln 2 scale, split in two partial products
  logic signed [47:0] th_x, ln2_x, ph_d, ph_q;
  logic [45:0]        pl_d, pl_q;

  assign th_x  = 48'($signed(t_q[TW-1:18]));
  assign ln2_x = 48'(LN2_Q28);
  assign ph_d  = th_x * ln2_x;
  assign pl_d  = 46'(t_q[17:0]) * 46'(LN2_Q28);

  // sum of partial products, round half up back to Q.28
  logic signed [65:0] s_sum, s_rnd;
  logic [TW-1:0]      l_d, l_q;

  assign s_sum = (66'(ph_q) <<< 18) + $signed(66'(pl_q));
  assign s_rnd = s_sum + (66'sd1 <<< (LOG_FRAC - 1));
  assign l_d   = s_rnd[LOG_FRAC+TW-1:LOG_FRAC];

  // gain a, split in two partial products
  logic signed [42:0] lx_l, lx_h, ax, ql_d, qh_d, ql_q, qh_q;

  assign lx_l = 43'($signed({1'b0, l_q[17:0]}));
  assign lx_h = 43'($signed(l_q[TW-1:18]));
  assign ax   = 43'(a_ln[NCELL+6]);
  assign ql_d = lx_l * ax;
  assign qh_d = lx_h * ax;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q        <= t_d;
      lin_ln[0]  <= lin_d;
      bigl_ln[0] <= big_d;
      for (int i = 1; i < 4; i++) begin
        lin_ln[i]  <= lin_ln[i-1];
        bigl_ln[i] <= bigl_ln[i-1];
      end
      ph_q <= ph_d;
      pl_q <= pl_d;
      l_q  <= l_d;
      ql_q <= ql_d;
      qh_q <= qh_d;
    end
  end

  // last stage: final shift per log law, saturation, status
  logic signed [YW-1:0] y_sum, y_lsq, y_log, y_sel;
  logic [OW-1:0]        det_d, out_data_q;
  logic [1:0]           st_d, out_status_q;
  logic                 out_eom_q;
  ctl_t                 ctl_o;

  assign ctl_o = ctl_q[NST-1];
  assign y_sum = (YW'(qh_q) <<< 18) + YW'(ql_q);
  assign y_lsq = (y_sum + (YW'(1) <<< (SH_LSQ - 1))) >>> SH_LSQ;
  assign y_log = (y_sum + (YW'(1) <<< (SH_LOG - 1))) >>> SH_LOG;
  assign y_sel = (ctl_o.det_type == DET_LOG) ? y_log : y_lsq;

  always_comb begin
    det_d = '0;
    st_d  = ST_OK;
    if (ctl_o.det_type inside {DET_ENV, DET_SQUARE}) begin
      if (bigl_ln[3]) begin
        det_d = OMAX_U;
        st_d  = ST_SAT;
      end else begin
        det_d = lin_ln[3];
      end
    end else if (ctl_o.log_zero) begin
      det_d = OMIN_U;
      st_d  = ST_LOGZERO;
    end else if (y_sel > YMAX) begin
      det_d = OMAX_U;
      st_d  = ST_SAT;
    end else if (y_sel < YMIN) begin
      det_d = OMIN_U;
      st_d  = ST_SAT;
    end else begin
      det_d = y_sel[OW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_o.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q   <= det_d;
      out_status_q <= st_d;
      out_eom_q    <= ctl_o.eom;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DOUT_W'(out_data_q);
  assign m_axis_tlast  = out_eom_q;
  assign m_axis_tuser  = out_status_q;

  // checks
  `RDL_ASSERT(a_logzero_min,
    out_valid_q && out_status_q == ST_LOGZERO |-> out_data_q == OMIN_U,
    "log of zero result is not the most negative value")
  `RDL_ASSERT(a_sat_ends,
    out_valid_q && out_status_q == ST_SAT |-> out_data_q == OMAX_U || out_data_q == OMIN_U,
    "saturated result is not at a range end")
  `RDL_ASSERT(a_stall_hold,
    !en |=> $stable(ctl_q[NST-1]) && $stable(out_data_q) && $stable(out_status_q),
    "pipe moved while the output was held")
  `RDL_ASSERT_ALWAYS(a_rst_idle,
    !rst_ni |=> !out_valid_q,
    "result valid right after reset")

endmodule

### rtl/core/rdl_lognorm.sv
// two-stage leading-one search and normalization for the log2 front end
// depends on rdl_pkg
module rdl_lognorm (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rdl_pkg::NORM_W-1:0] v_i,
  output logic [rdl_pkg::EXP_W-1:0]  exp_o,
  output logic [rdl_pkg::MANT_W-1:0] mant_o
);
  import rdl_pkg::*;

  localparam int NB = NORM_W / 8;

  logic [2:0]        c_d, c_q, k_d;
  logic [NORM_W-1:0] v1_d, v1_q, v2;
  logic [EXP_W-1:0]  exp_d, exp_q;
  logic [MANT_W-1:0] mant_d, mant_q;

  // coarse step: top nonzero byte moves to the top
  always_comb begin
    c_d = '0;
    for (int i = 0; i < NB; i++) begin
      if (v_i[8*i +: 8] != '0) c_d = 3'(i);
    end
    v1_d = v_i << {~c_d, 3'b000};
  end

  // fine step: top bit within that byte
  always_comb begin
    k_d = '0;
    for (int i = 0; i < 8; i++) begin
      if (v1_q[NORM_W-8+i]) k_d = 3'(i);
    end
    v2     = v1_q << ~k_d;
    exp_d  = {c_q, k_d};
    mant_d = v2[NORM_W-1 -: MANT_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v1_q   <= v1_d;
      c_q    <= c_d;
      exp_q  <= exp_d;
      mant_q <= mant_d;
    end
  end

  assign exp_o  = exp_q;
  assign mant_o = mant_q;

endmodule

### rtl/core/rdl_cell.sv
// one cell of the detector row: one square-root digit (if IDX < NSQ) and one log2 fraction bit
// for both log operands (if IDX < LOG_FRAC) per cycle while en_i is high; depends on rdl_pkg
module rdl_cell #(
  parameter int SAMPLE_WIDTH = rdl_pkg::SAMPLE_WIDTH_DEF,
  parameter int OUT_WIDTH    = rdl_pkg::OUT_WIDTH_DEF,
  parameter int IDX          = 0
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [2*SAMPLE_WIDTH-1:0]    p_i,
  output logic [2*SAMPLE_WIDTH-1:0]    p_o,
  input  logic [OUT_WIDTH-8:0]         root_i,
  output logic [OUT_WIDTH-8:0]         root_o,
  input  logic [OUT_WIDTH-5:0]         rem_i,
  output logic [OUT_WIDTH-5:0]         rem_o,
  input  logic [rdl_pkg::MANT_W-1:0]   mb_i,
  output logic [rdl_pkg::MANT_W-1:0]   mb_o,
  input  logic [rdl_pkg::MANT_W-1:0]   mp_i,
  output logic [rdl_pkg::MANT_W-1:0]   mp_o,
  input  logic [rdl_pkg::LOG_FRAC-1:0] fb_i,
  output logic [rdl_pkg::LOG_FRAC-1:0] fb_o,
  input  logic [rdl_pkg::LOG_FRAC-1:0] fp_i,
  output logic [rdl_pkg::LOG_FRAC-1:0] fp_o
);
  import rdl_pkg::*;

  localparam int NSQ = OUT_WIDTH - 7;
  localparam int RW  = NSQ + 3;
  localparam int POS = SAMPLE_WIDTH - 1 - IDX;

  // square the mantissa, renormalize, report the fraction bit
  function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
    logic [2*MANT_W-1:0] pr;
    logic [MANT_W:0]     t;
    pr = (2*MANT_W)'(m) * (2*MANT_W)'(m);
    t  = pr[2*MANT_W-1:MANT_W-1];
    return t[MANT_W] ? {1'b1, t[MANT_W:1]} : {1'b0, t[MANT_W-1:0]};
  endfunction

  logic [1:0]          dig;
  logic [RW-1:0]       rem_sh, trial, rem_d;
  logic [NSQ-1:0]      root_d;
  logic [MANT_W:0]     sb, sp;
  logic [MANT_W-1:0]   mb_d, mp_d;
  logic [LOG_FRAC-1:0] fb_d, fp_d;

  if (POS >= 0) begin : g_dig
    assign dig = p_i[2*POS +: 2];
  end else begin : g_nodig
    assign dig = 2'b00;
  end

  always_comb begin
    rem_sh = {rem_i[RW-3:0], dig};
    trial  = RW'({root_i, 2'b01});
    root_d = root_i;
    rem_d  = rem_i;
    if (IDX < NSQ) begin
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_i[NSQ-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_i[NSQ-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    sb   = sq_step(mb_i);
    sp   = sq_step(mp_i);
    mb_d = mb_i;
    mp_d = mp_i;
    fb_d = fb_i;
    fp_d = fp_i;
    if (IDX < LOG_FRAC) begin
      mb_d = sb[MANT_W-1:0];
      mp_d = sp[MANT_W-1:0];
      fb_d = {fb_i[LOG_FRAC-2:0], sb[MANT_W]};
      fp_d = {fp_i[LOG_FRAC-2:0], sp[MANT_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o    <= p_i;
      root_o <= root_d;
      rem_o  <= rem_d;
      mb_o   <= mb_d;
      mp_o   <= mp_d;
      fb_o   <= fb_d;
      fp_o   <= fp_d;
    end
  end

endmodule

### tb/sv/tb_radar_detector_law_core.sv
// testbench for radar_detector_law_core: all four detector laws, log of zero, saturation
// depends on rdl_pkg and the core; self-checking against an in-bench fixed-point model
`timescale 1ns / 1ps

module tb_radar_detector_law_core;
  import rdl_pkg::*;

  localparam int  LATENCY    = 37;
  localparam int  DRAIN_WAIT = LATENCY + 8;
  localparam int  CYCLE_MAX  = 400000;
  localparam int  RAND_PHASES = 6;
  localparam int  PHASE_ITEMS = 75;
  // unused register index, writes there are dropped
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam longint signed OMAX = 64'sd2147483647;
  localparam longint signed OMIN = -64'sd2147483648;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // in_real, in_imag
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // detected
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  // result_status
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_TYPE;
  logic [23:0] cfg_data_i = '0;

  radar_detector_law_core dut (.*);

  always #5 clk_i = ~clk_i;

  // expected detector output per accepted sample
  typedef struct {
    logic [31:0] det;
    logic        eom;
    logic [1:0]  st;
  } detect_t;

  detect_t     det_q[$];
  det_e        law_m = DET_SQUARE;
  logic signed [23:0] coef_a_m = COEF_RST;
  logic [23:0] coef_b_m = COEF_RST;
  int          err_cnt = 0;
  int          res_cnt = 0;
  int          cfg_cnt = 0;
  int          sat_cnt = 0;
  int          zero_cnt = 0;
  int          cyc = 0;
  int          burst_left = 0;

  // log2 of nonzero v in Q.28, mantissa by repeated squaring
  function automatic longint signed log2_q28(longint unsigned v);
    int e;
    longint unsigned m, fr;
    e = 63;
    fr = 0;
    while (e > 0 && !v[e]) e--;
    m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= 64'h1_0000_0000) begin
        fr = fr | 64'd1;
        m = m >> 1;
      end
    end
    return (longint'(e) <<< LOG_FRAC) | longint'(fr);
  endfunction

  // signed shift right with rounding half up
  function automatic longint signed rnd_shift(longint signed x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic detect_t detect_law(logic signed [15:0] re, logic signed [15:0] im,
                                         logic eom);
    detect_t r;
    longint signed ri, ii, y, t, l;
    longint unsigned p, u, rem, root, trial, sub;
    bit big;
    int pos;
    ri = re;
    ii = im;
    p = longint'(ri * ri + ii * ii);
    y = 0;
    big = 0;
    r.st = ST_OK;
    r.eom = eom;
    if (law_m == DET_SQUARE) begin
      u = (p + 64'd32) >> 6;
      if (u > OMAX) big = 1; else y = longint'(u);
    end else if (law_m == DET_ENV) begin
      // digit by digit root of p * 4^9
      rem = 0;
      root = 0;
      for (int k = 40; k >= 0; k--) begin
        pos = k - 9;
        rem = rem << 2;
        if (pos >= 0 && pos < 32) begin
          sub = (p >> (2 * pos)) & 64'd3;
          rem = rem | sub;
        end
        trial = (root << 2) | 64'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      if (rem > root) root++;
      if (root > OMAX) big = 1; else y = longint'(root);
    end else if (p == 0 || coef_b_m == 0) begin
      y = OMIN;
      r.st = ST_LOGZERO;
    end else begin
      t = 2 * log2_q28(longint'(coef_b_m)) + log2_q28(p) - (64'sd62 <<< LOG_FRAC);
      l = rnd_shift(t * longint'(LN2_Q28), LOG_FRAC);
      y = rnd_shift(l * longint'(coef_a_m), (law_m == DET_LOG) ? 21 : 20);
    end
    if (big || y > OMAX) begin
      y = OMAX;
      r.st = ST_SAT;
    end else if (y < OMIN) begin
      y = OMIN;
      r.st = ST_SAT;
    end
    r.det = y[31:0];
    return r;
  endfunction

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    detect_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      res_cnt++;
      if (det_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result det=%h st=%0d", m_axis_tdata,
                                    m_axis_tuser);
      end else begin
        e = det_q.pop_front();
        if (e.st == ST_SAT) sat_cnt++;
        if (e.st == ST_LOGZERO) zero_cnt++;
        if (m_axis_tdata !== e.det || m_axis_tlast !== e.eom || m_axis_tuser !== e.st) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch: exp det=%h eom=%b st=%0d, got det=%h eom=%b st=%0d",
                     e.det, e.eom, e.st, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // sink stall pattern, one of four randomly drawn modes: always ready, random, mostly stalled, periodic
  always @(negedge clk_i) begin
    int stall_mode;
    if (cyc % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = $urandom_range(0, 1);
      2: m_axis_tready = ($urandom_range(0, 3) == 0);
      default: m_axis_tready = ((cyc % 16) < 12);
    endcase
  end

  // watchdog
  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CYCLE_MAX) begin
      $display("timeout after %0d cycles", cyc);
      $display("Some tests failed");
      $finish;
    end
  end

  // register write, called at a falling edge while the core is empty
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      REG_TYPE:   law_m = det_e'(val[1:0]);
      REG_COEF_A: coef_a_m = val;
      REG_COEF_B: coef_b_m = val;
      default: ;
    endcase
    cfg_cnt++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // stop sending and wait for every outstanding result plus pipeline flush
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (det_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic set_law(det_e law, logic [23:0] a, logic [23:0] b);
    if (law != law_m || a != coef_a_m || b != coef_b_m) begin
      drain();
      write_reg(REG_TYPE, 24'(law));
      write_reg(REG_COEF_A, a);
      write_reg(REG_COEF_B, b);
    end
  endtask

  // one sample request in bursts; entered and left at a falling edge
  task automatic send_sample(logic [15:0] re, logic [15:0] im, logic eom,
                             bit fixed, detect_t fixed_res);
    detect_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {im, re};
    s_axis_tlast = eom;
    r = fixed ? fixed_res : detect_law(re, im, eom);
    do @(posedge clk_i); while (!s_axis_tready);
    det_q.push_back(r);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h0001;
          default: return 16'hffff;
        endcase
      end
      1: return 16'($urandom_range(0, 255)) ^ ($urandom_range(0, 1) ? 16'hffff : 16'h0);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'hffffff;
      3: return 24'd1;
      4: return COEF_RST;
      default: return 24'($urandom);
    endcase
  endfunction

  typedef struct {
    det_e        law;
    logic [23:0] a, b;
    logic [15:0] re, im;
    logic        eom;
    bit          fixed;
    logic [31:0] det;
    logic [1:0]  st;
  } dir_row_t;

  dir_row_t dir_tab [0:16];

  initial begin
    detect_t fr;
    logic [23:0] ra, rb;
    // directed rows; fixed ones carry results read off the law definitions
    dir_tab = '{
      '{DET_SQUARE, 24'd65536, 24'd65536, 16'h0000, 16'h0000, 1'b0, 1, 32'd0, ST_OK},
      '{DET_SQUARE, 24'd65536, 24'd65536, 16'h8000, 16'h8000, 1'b1, 1, 32'd33554432, ST_OK},
      '{DET_SQUARE, 24'd65536, 24'd65536, 16'h7fff, 16'h8000, 1'b0, 0, 32'd0, ST_OK},
      '{DET_SQUARE, 24'd65536, 24'd65536, 16'h0001, 16'h0001, 1'b0, 0, 32'd0, ST_OK},
      '{DET_ENV,    24'd65536, 24'd65536, 16'h0000, 16'h0000, 1'b0, 1, 32'd0, ST_OK},
      '{DET_ENV,    24'd65536, 24'd65536, 16'h7fff, 16'h0000, 1'b1, 1, 32'd16776704, ST_OK},
      '{DET_ENV,    24'd65536, 24'd65536, 16'h0001, 16'h0000, 1'b0, 1, 32'd512, ST_OK},
      '{DET_ENV,    24'd65536, 24'd65536, 16'h8000, 16'h8000, 1'b0, 0, 32'd0, ST_OK},
      '{DET_LOGSQ,  24'd65536, 24'd65536, 16'h0000, 16'h0000, 1'b0, 1, 32'h80000000,
        ST_LOGZERO},
      '{DET_LOGSQ,  24'd65536, 24'd65536, 16'h4000, 16'h0000, 1'b1, 0, 32'd0, ST_OK},
      '{DET_LOGSQ,  24'd65536, 24'd65536, 16'h8000, 16'h8000, 1'b0, 0, 32'd0, ST_OK},
      '{DET_LOG,    24'd65536, 24'd65536, 16'h0000, 16'h0000, 1'b0, 1, 32'h80000000,
        ST_LOGZERO},
      '{DET_LOG,    24'd65536, 24'd65536, 16'h0001, 16'h0001, 1'b0, 0, 32'd0, ST_OK},
      '{DET_LOG,    24'h7fffff, 24'hffffff, 16'h7fff, 16'h7fff, 1'b0, 0, 32'd0, ST_OK},
      '{DET_LOG,    24'h800000, 24'd1, 16'h0001, 16'h0000, 1'b1, 0, 32'd0, ST_OK},
      // zero input scale b is a log of zero for any sample and any gain
      '{DET_LOGSQ,  24'h800000, 24'd0, 16'd100, 16'd100, 1'b0, 1, 32'h80000000,
        ST_LOGZERO},
      '{DET_LOGSQ,  24'd0, 24'd65536, 16'd5, 16'd5, 1'b0, 1, 32'd0, ST_OK}
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // unused index must leave every register alone
    write_reg(REG_NONE, 24'hffffff);

    foreach (dir_tab[i]) begin
      set_law(dir_tab[i].law, dir_tab[i].a, dir_tab[i].b);
      fr.det = dir_tab[i].det;
      fr.eom = dir_tab[i].eom;
      fr.st = dir_tab[i].st;
      send_sample(dir_tab[i].re, dir_tab[i].im, dir_tab[i].eom, dir_tab[i].fixed, fr);
    end

    // random phases, each with its own law and coefficients; drain in between
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      ra = pick_coef();
      rb = pick_coef();
      // first phases hit each law once, later ones pick freely
      drain();
      write_reg(REG_TYPE, 24'((ph < 4) ? ph : $urandom_range(0, 3)));
      write_reg(REG_COEF_A, ra);
      write_reg(REG_COEF_B, rb);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_sample(pick_sample(), pick_sample(), ($urandom_range(0, 7) == 0), 0, fr);
    end

    drain();
    $display("checked %0d results over %0d register writes", res_cnt, cfg_cnt);
    $display("saturated results %0d, log of zero results %0d", sat_cnt, zero_cnt);
    if (err_cnt == 0 && det_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", err_cnt, det_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
